[rtl/ssv_pkg.sv]
// Shared constants, codes, command/status types, tables and rounding helper
// for the scanned string voice. No dependencies.
`timescale 1ns / 1ps
package ssv_pkg;

    // String geometry and number formats
    localparam int NODES      = 64;
    localparam int NODE_W     = $clog2(NODES);
    localparam int POS_BITS   = 24;
    localparam int FRAC       = POS_BITS - 4;
    localparam int DC_BITS    = POS_BITS + 4;
    localparam int OUT_BITS   = 16;
    localparam int PHASE_BITS = 24;

    localparam int BUMP_A     = 8;
    localparam int BUMP_B     = 40;
    localparam int DRONE_GAIN = 1311;
    localparam int DC_POLE    = 16760439;
    localparam int OUT_FS     = (1 << (OUT_BITS - 1)) - 1;
    localparam int POS_CLIP   = 4 << FRAC;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_ADDR_W-1:0] REG_TENSION   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DAMPING   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTERING = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HAMMER    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SHAPE     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_DRONE     = 3'd6;

    // Excitation shapes
    localparam logic [1:0] SHAPE_PULSE = 2'd0;
    localparam logic [1:0] SHAPE_BUMP  = 2'd1;
    localparam logic [1:0] SHAPE_PAIR  = 2'd2;
    localparam logic [1:0] SHAPE_NOISE = 2'd3;

    // Datapath micro-operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP = 5'd0;
    localparam logic [OP_W-1:0] OP_CLR = 5'd1;
    localparam logic [OP_W-1:0] OP_X0  = 5'd2;
    localparam logic [OP_W-1:0] OP_X1  = 5'd3;
    localparam logic [OP_W-1:0] OP_X2  = 5'd4;
    localparam logic [OP_W-1:0] OP_X3  = 5'd5;
    localparam logic [OP_W-1:0] OP_DI0 = 5'd6;
    localparam logic [OP_W-1:0] OP_DI1 = 5'd7;
    localparam logic [OP_W-1:0] OP_DI2 = 5'd8;
    localparam logic [OP_W-1:0] OP_D0  = 5'd9;
    localparam logic [OP_W-1:0] OP_D1  = 5'd10;
    localparam logic [OP_W-1:0] OP_D2  = 5'd11;
    localparam logic [OP_W-1:0] OP_D3  = 5'd12;
    localparam logic [OP_W-1:0] OP_D4  = 5'd13;
    localparam logic [OP_W-1:0] OP_D5  = 5'd14;
    localparam logic [OP_W-1:0] OP_S0  = 5'd15;
    localparam logic [OP_W-1:0] OP_S1  = 5'd16;
    localparam logic [OP_W-1:0] OP_S2  = 5'd17;
    localparam logic [OP_W-1:0] OP_S3  = 5'd18;
    localparam logic [OP_W-1:0] OP_S4  = 5'd19;
    localparam logic [OP_W-1:0] OP_S5  = 5'd20;
    localparam logic [OP_W-1:0] OP_S6  = 5'd21;
    localparam logic [OP_W-1:0] OP_S7  = 5'd22;
    localparam logic [OP_W-1:0] OP_S8  = 5'd23;
    localparam logic [OP_W-1:0] OP_S9  = 5'd24;
    localparam logic [OP_W-1:0] OP_S10 = 5'd25;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [NODE_W-1:0] idx;
        logic              amt_sel;   // 1: hammer, 0: drone amount
    } ssv_cmd_t;

    typedef struct packed {
        logic       out_free;
        logic [1:0] shape;
        logic       drone_en;
    } ssv_stat_t;

    // Raised-cosine weights, Q1.16
    function automatic logic [16:0] bump_w(input logic [3:0] j);
        logic [16:0] w;
        case (j)
            4'd0:    w = 17'd0;
            4'd1:    w = 17'd2494;
            4'd2:    w = 17'd9598;
            4'd3:    w = 17'd20228;
            4'd4:    w = 17'd32768;
            4'd5:    w = 17'd45308;
            4'd6:    w = 17'd55938;
            4'd7:    w = 17'd63042;
            4'd8:    w = 17'd65536;
            4'd9:    w = 17'd63042;
            4'd10:   w = 17'd55938;
            4'd11:   w = 17'd45308;
            4'd12:   w = 17'd32768;
            4'd13:   w = 17'd20228;
            4'd14:   w = 17'd9598;
            default: w = 17'd2494;
        endcase
        return w;
    endfunction

    // tanh(2.5x) for x = 0..2 in steps of 1/16, Q0.16
    function automatic logic [15:0] tanh_val(input logic [5:0] i);
        logic [15:0] t;
        case (i)
            6'd0:  t = 16'd0;     6'd1:  t = 16'd10157; 6'd2:  t = 16'd19838;
            6'd3:  t = 16'd28651; 6'd4:  t = 16'd36346; 6'd5:  t = 16'd42823;
            6'd6:  t = 16'd48108; 6'd7:  t = 16'd52314; 6'd8:  t = 16'd55593;
            6'd9:  t = 16'd58110; 6'd10: t = 16'd60019; 6'd11: t = 16'd61454;
            6'd12: t = 16'd62524; 6'd13: t = 16'd63319; 6'd14: t = 16'd63907;
            6'd15: t = 16'd64340; 6'd16: t = 16'd64659; 6'd17: t = 16'd64893;
            6'd18: t = 16'd65065; 6'd19: t = 16'd65191; 6'd20: t = 16'd65284;
            6'd21: t = 16'd65351; 6'd22: t = 16'd65401; 6'd23: t = 16'd65437;
            6'd24: t = 16'd65464; 6'd25: t = 16'd65483; 6'd26: t = 16'd65497;
            6'd27: t = 16'd65508; 6'd28: t = 16'd65515; 6'd29: t = 16'd65521;
            6'd30: t = 16'd65525; 6'd31: t = 16'd65528;
            default: t = 16'd65530;
        endcase
        return t;
    endfunction

    // Arithmetic right shift, rounding half away from zero
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x,
                                                   input int unsigned s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 1);
        return (x + half - $signed({63'd0, x[63]})) >>> s;
    endfunction

endpackage

[rtl/ssv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ssv_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

[rtl/ssv_dp.sv]
// Datapath: configuration registers, node memories, excitation, string step,
// scan/DC-block/soft-clip chain and output register. Uses ssv_pkg, ssv_ram.
`timescale 1ns / 1ps
module ssv_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic [ssv_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ssv_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  ssv_pkg::ssv_cmd_t                 cmd,
    output ssv_pkg::ssv_stat_t                stat,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ssv_pkg::OUT_BITS-1:0]      m_tdata
);
    import ssv_pkg::*;

    // Configuration registers
    logic [15:0] tension_reg, damping_reg, centering_reg;
    logic [16:0] hammer_reg;
    logic [PHASE_BITS-1:0] phase_step_reg;
    logic [1:0]  shape_reg;
    logic        drone_reg;
    logic [16:0] drone_amt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tension_reg    <= 16'd1311;
            damping_reg    <= 16'd33;
            centering_reg  <= 16'd0;
            hammer_reg     <= 17'd0;
            phase_step_reg <= 24'd153791;
            shape_reg      <= SHAPE_PULSE;
            drone_reg      <= 1'b0;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                REG_TENSION:   tension_reg    <= cfg_wdata[15:0];
                REG_DAMPING:   damping_reg    <= cfg_wdata[15:0];
                REG_CENTERING: centering_reg  <= cfg_wdata[15:0];
                REG_HAMMER:    hammer_reg     <= cfg_wdata[16:0];
                REG_PHASE:     phase_step_reg <= cfg_wdata[PHASE_BITS-1:0];
                REG_SHAPE:     shape_reg      <= cfg_wdata[1:0];
                REG_DRONE:     drone_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Drone amount, hammer * 0.02
    logic [27:0] drone_prod;
    assign drone_prod = 28'(hammer_reg) * 28'(DRONE_GAIN);
    always_ff @(posedge aclk) begin
        drone_amt_reg <= 17'((drone_prod + 28'd32768) >> 16);
    end

    // Node memories
    logic                pos_we, prev_we;
    logic [NODE_W-1:0]   pos_raddr, prev_raddr, pos_waddr;
    logic [POS_BITS-1:0] pos_wdata, prev_wdata, pos_rdata, prev_rdata;

    ssv_ram #(.WIDTH(POS_BITS), .DEPTH(NODES)) u_pos_ram (
        .aclk(aclk), .wr_en(pos_we), .wr_addr(pos_waddr), .wr_data(pos_wdata),
        .rd_addr(pos_raddr), .rd_data(pos_rdata)
    );
    ssv_ram #(.WIDTH(POS_BITS), .DEPTH(NODES)) u_prev_ram (
        .aclk(aclk), .wr_en(prev_we), .wr_addr(cmd.idx), .wr_data(prev_wdata),
        .rd_addr(prev_raddr), .rd_data(prev_rdata)
    );

    // Excitation node, weight and amount
    logic [NODE_W-1:0]      xnode;
    logic signed [24:0]     xw;
    logic [16:0]            xamt;
    logic [PHASE_BITS-1:0]  phase_reg;
    logic [NODE_W-1:0]      i0;
    logic [31:0]            seed_reg;

    assign i0   = phase_reg[PHASE_BITS-1 -: NODE_W];
    assign xamt = cmd.amt_sel ? hammer_reg : drone_amt_reg;

    // Excitation writes go to the excited node, all others to the walked index
    assign pos_waddr = (cmd.op == OP_X3) ? xnode : cmd.idx;

    always_comb begin
        case (shape_reg)
            SHAPE_PULSE: begin
                xnode = NODE_W'(NODES / 4);
                xw    = 25'sd65536;
            end
            SHAPE_BUMP: begin
                xnode = NODE_W'(NODES / 4) + cmd.idx;
                xw    = $signed({8'd0, bump_w(cmd.idx[3:0])});
            end
            SHAPE_PAIR: begin
                xnode = (cmd.idx[0] ? NODE_W'(BUMP_B) : NODE_W'(BUMP_A))
                        + NODE_W'(cmd.idx[3:1]);
                xw    = $signed({8'd0, bump_w({cmd.idx[3:1], 1'b0})});
            end
            default: begin
                xnode = cmd.idx;
                xw    = 25'($signed({~seed_reg[31], seed_reg[30:9]}));
            end
        endcase
    end

    // Read address selection
    always_comb begin
        prev_raddr = cmd.idx;
        unique case (cmd.op) inside
            OP_X0, OP_X1, OP_X2, OP_X3: pos_raddr = xnode;
            OP_DI0: pos_raddr = NODE_W'(NODES - 1);
            OP_DI1: pos_raddr = '0;
            OP_D0:  pos_raddr = cmd.idx + NODE_W'(1);
            OP_S1:  pos_raddr = i0;
            OP_S2:  pos_raddr = i0 + NODE_W'(1);
            default: pos_raddr = cmd.idx;
        endcase
    end

    // Working registers
    logic signed [42:0]         prod_reg;
    logic signed [24:0]         delta_reg;
    logic signed [POS_BITS-1:0] pl_reg, pc_reg, p0_reg, pr_reg, prv_reg;
    logic signed [43:0]         m1_reg;
    logic signed [41:0]         m2_reg;
    logic signed [25:0]         base_reg;
    logic signed [29:0]         v_reg;
    logic signed [47:0]         m3_reg;
    logic signed [POS_BITS-1:0] sa_reg, sb_reg, s_reg, dcin_reg;
    logic signed [50:0]         ma_reg, mb_reg;
    logic signed [53:0]         mdc_reg;
    logic signed [DC_BITS-1:0]  dcout_reg;
    logic                       neg_reg;
    logic [15:0]                tbase_reg, y_reg;
    logic [29:0]                ti_reg;
    logic [OUT_BITS+15:0]       yo_reg;
    logic                       out_valid_reg;
    logic [OUT_BITS-1:0]        out_data_reg;

    // Combinational helpers per step
    logic signed [63:0] xr, xsum, vsum, nxt, srnd, dcsum;
    logic signed [25:0] lap;
    logic [16:0]        decay;
    logic [PHASE_BITS-1:0] fr24;
    logic [24:0]        w0;
    logic [DC_BITS-1:0] dabs;
    logic [11:0]        seg;
    logic [15:0]        t_lo, t_hi;
    logic [OUT_BITS-1:0] ymag;

    assign xr    = rnd_shr(64'(prod_reg), (shape_reg == SHAPE_NOISE) ? 39 - FRAC : 32 - FRAC);
    assign xsum  = 64'($signed(pos_rdata)) + 64'(delta_reg);
    assign lap   = 26'(pl_reg) + 26'(pr_reg) - (26'(pc_reg) <<< 1);
    assign vsum  = (64'(base_reg) <<< 16) + 64'(m1_reg) - 64'(m2_reg);
    assign decay = 17'(18'd65536 - 18'(damping_reg));
    assign nxt   = rnd_shr(64'(m3_reg), 16);
    assign fr24  = {phase_reg[PHASE_BITS-1-NODE_W:0], NODE_W'(0)};
    assign w0    = 25'(1 << PHASE_BITS) - 25'(fr24);
    assign srnd  = rnd_shr(64'(ma_reg) + 64'(mb_reg), 24);
    assign dcsum = 64'(s_reg) - 64'(dcin_reg) + rnd_shr(64'(mdc_reg), 24);
    assign dabs  = dcout_reg[DC_BITS-1] ? DC_BITS'(-dcout_reg) : DC_BITS'(dcout_reg);
    assign seg   = dabs[DC_BITS-1:FRAC-4];
    assign t_lo  = tanh_val({1'b0, seg[4:0]});
    assign t_hi  = tanh_val(6'({1'b0, seg[4:0]} + 6'd1));
    assign ymag  = OUT_BITS'((yo_reg + (OUT_BITS+16)'(32768)) >> 16);

    // Memory writes
    always_comb begin
        pos_we     = 1'b0;
        prev_we    = 1'b0;
        pos_wdata  = '0;
        prev_wdata = '0;
        unique case (cmd.op) inside
            OP_CLR: begin
                pos_we  = 1'b1;
                prev_we = 1'b1;
            end
            OP_X3: begin
                pos_we = 1'b1;
                if (xsum > 64'((1 << (POS_BITS - 1)) - 1)) begin
                    pos_wdata = POS_BITS'((1 << (POS_BITS - 1)) - 1);
                end else if (xsum < -64'(1 << (POS_BITS - 1))) begin
                    pos_wdata = POS_BITS'(1 << (POS_BITS - 1));
                end else begin
                    pos_wdata = POS_BITS'(xsum);
                end
            end
            OP_D5: begin
                pos_we     = 1'b1;
                prev_we    = 1'b1;
                prev_wdata = pc_reg;
                if (nxt > 64'(POS_CLIP)) begin
                    pos_wdata = POS_BITS'(POS_CLIP);
                end else if (nxt < -64'(POS_CLIP)) begin
                    pos_wdata = POS_BITS'(-POS_CLIP);
                end else begin
                    pos_wdata = POS_BITS'(nxt);
                end
            end
            default: ;
        endcase
    end

    // State registers of the voice
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= 32'd1;
            phase_reg     <= '0;
            dcin_reg      <= '0;
            dcout_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_X0 && shape_reg == SHAPE_NOISE) begin
                seed_reg <= seed_reg * 32'd1664525 + 32'd1013904223;
            end
            if (cmd.op == OP_S0) begin
                phase_reg <= phase_reg + phase_step_reg;
            end
            if (cmd.op == OP_S6) begin
                dcin_reg <= s_reg;
                if (dcsum > 64'((1 << (DC_BITS - 1)) - 1)) begin
                    dcout_reg <= DC_BITS'((1 << (DC_BITS - 1)) - 1);
                end else if (dcsum < -64'(1 << (DC_BITS - 1))) begin
                    dcout_reg <= DC_BITS'(1 << (DC_BITS - 1));
                end else begin
                    dcout_reg <= DC_BITS'(dcsum);
                end
            end
            if (cmd.op == OP_S10) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Arithmetic pipeline registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_X1: prod_reg <= $signed({1'b0, xamt}) * xw;
            OP_X2: delta_reg <= (shape_reg == SHAPE_PAIR && cmd.idx[0]) ? -25'(xr) : 25'(xr);
            OP_DI1: pl_reg <= $signed(pos_rdata);
            OP_DI2: begin
                pc_reg <= $signed(pos_rdata);
                p0_reg <= $signed(pos_rdata);
            end
            OP_D1: begin
                pr_reg  <= (cmd.idx == NODE_W'(NODES - 1)) ? p0_reg : $signed(pos_rdata);
                prv_reg <= $signed(prev_rdata);
            end
            OP_D2: begin
                m1_reg   <= $signed({1'b0, tension_reg}) * lap;
                m2_reg   <= $signed({1'b0, centering_reg}) * pc_reg;
                base_reg <= (26'(pc_reg) <<< 1) - 26'(prv_reg);
            end
            OP_D3: v_reg <= 30'(rnd_shr(vsum, 16));
            OP_D4: m3_reg <= v_reg * $signed({1'b0, decay});
            OP_D5: begin
                pl_reg <= pc_reg;
                pc_reg <= pr_reg;
            end
            OP_S2: sa_reg <= $signed(pos_rdata);
            OP_S3: sb_reg <= $signed(pos_rdata);
            OP_S4: begin
                ma_reg <= sa_reg * $signed({1'b0, w0});
                mb_reg <= sb_reg * $signed({2'b0, fr24});
            end
            OP_S5: begin
                s_reg   <= POS_BITS'(srnd);
                mdc_reg <= dcout_reg * $signed({1'b0, 25'(DC_POLE)});
            end
            OP_S7: begin
                neg_reg <= dcout_reg[DC_BITS-1];
                if (seg >= 12'd32) begin
                    tbase_reg <= tanh_val(6'd32);
                    ti_reg    <= '0;
                end else begin
                    tbase_reg <= t_lo;
                    ti_reg    <= 30'(t_hi - t_lo) * 30'(dabs[FRAC-5:0]);
                end
            end
            OP_S8: y_reg <= tbase_reg + 16'((ti_reg + 30'd32768) >> 16);
            OP_S9: yo_reg <= (OUT_BITS+16)'(y_reg) * (OUT_BITS+16)'(OUT_FS);
            OP_S10: out_data_reg <= neg_reg ? -ymag : ymag;
            default: ;
        endcase
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.shape    = shape_reg;
    assign stat.drone_en = drone_reg;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;

    // Checks
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_S10) |=> out_valid_reg)
        else $error("result not presented after load");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_S10) |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");
    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_D5) |-> ($signed(pos_wdata) <= POS_CLIP && $signed(pos_wdata) >= -POS_CLIP))
        else $error("string node outside clip range");
endmodule

[rtl/ssv_ctrl.sv]
// Controller: sequences clearing, excitation passes, string step and sample
// computation as datapath micro-operations. Uses ssv_pkg.
`timescale 1ns / 1ps
module ssv_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tuser,
    input  ssv_pkg::ssv_stat_t stat,
    output ssv_pkg::ssv_cmd_t  cmd
);
    import ssv_pkg::*;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_XP    = 3'd2;
    localparam logic [2:0] ST_DINIT = 3'd3;
    localparam logic [2:0] ST_DYN   = 3'd4;
    localparam logic [2:0] ST_SCAN  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [3:0]        sub_reg, sub_next;
    logic [NODE_W-1:0] idx_reg, idx_next, last_idx;
    logic              amt_reg, amt_next;
    logic              pluck_reg, pluck_next;
    logic              gate_prev_reg, gate_prev_next;
    logic              rising;

    assign s_tready = (state_reg == ST_IDLE);
    assign rising   = s_tdata[0] && !gate_prev_reg;

    // Entries per excitation pass
    always_comb begin
        case (stat.shape)
            SHAPE_PULSE: last_idx = '0;
            SHAPE_NOISE: last_idx = NODE_W'(NODES - 1);
            default:     last_idx = NODE_W'(15);
        endcase
    end

    // Next state
    always_comb begin
        state_next     = state_reg;
        sub_next       = sub_reg + 4'd1;
        idx_next       = idx_reg;
        amt_next       = amt_reg;
        pluck_next     = pluck_reg;
        gate_prev_next = gate_prev_reg;
        unique case (state_reg)
            ST_CLR: begin
                sub_next = '0;
                idx_next = idx_reg + NODE_W'(1);
                if (idx_reg == NODE_W'(NODES - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                sub_next = '0;
                idx_next = '0;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        state_next = ST_SCAN;
                    end else begin
                        gate_prev_next = s_tdata[0];
                        if (stat.drone_en) begin
                            state_next = ST_XP;
                            amt_next   = 1'b0;
                            pluck_next = rising;
                        end else if (rising) begin
                            state_next = ST_XP;
                            amt_next   = 1'b1;
                            pluck_next = 1'b0;
                        end else begin
                            state_next = ST_DINIT;
                        end
                    end
                end
            end
            ST_XP: begin
                if (sub_reg == 4'd3) begin
                    sub_next = '0;
                    if (idx_reg != last_idx) begin
                        idx_next = idx_reg + NODE_W'(1);
                    end else begin
                        idx_next = '0;
                        if (pluck_reg) begin
                            amt_next   = 1'b1;
                            pluck_next = 1'b0;
                        end else begin
                            state_next = ST_DINIT;
                        end
                    end
                end
            end
            ST_DINIT: begin
                if (sub_reg == 4'd2) begin
                    sub_next   = '0;
                    idx_next   = '0;
                    state_next = ST_DYN;
                end
            end
            ST_DYN: begin
                if (sub_reg == 4'd5) begin
                    sub_next = '0;
                    idx_next = idx_reg + NODE_W'(1);
                    if (idx_reg == NODE_W'(NODES - 1)) state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (sub_reg == 4'd9) state_next = ST_OUT;
            end
            ST_OUT: begin
                sub_next = '0;
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            sub_reg       <= '0;
            idx_reg       <= '0;
            amt_reg       <= 1'b0;
            pluck_reg     <= 1'b0;
            gate_prev_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sub_reg       <= sub_next;
            idx_reg       <= idx_next;
            amt_reg       <= amt_next;
            pluck_reg     <= pluck_next;
            gate_prev_reg <= gate_prev_next;
        end
    end

    // Micro-operation for the datapath
    always_comb begin
        cmd.idx     = idx_reg;
        cmd.amt_sel = amt_reg;
        cmd.op      = OP_NOP;
        unique case (state_reg)
            ST_CLR: cmd.op = OP_CLR;
            ST_XP: begin
                case (sub_reg)
                    4'd0:    cmd.op = OP_X0;
                    4'd1:    cmd.op = OP_X1;
                    4'd2:    cmd.op = OP_X2;
                    default: cmd.op = OP_X3;
                endcase
            end
            ST_DINIT: begin
                case (sub_reg)
                    4'd0:    cmd.op = OP_DI0;
                    4'd1:    cmd.op = OP_DI1;
                    default: cmd.op = OP_DI2;
                endcase
            end
            ST_DYN: begin
                case (sub_reg)
                    4'd0:    cmd.op = OP_D0;
                    4'd1:    cmd.op = OP_D1;
                    4'd2:    cmd.op = OP_D2;
                    4'd3:    cmd.op = OP_D3;
                    4'd4:    cmd.op = OP_D4;
                    default: cmd.op = OP_D5;
                endcase
            end
            ST_SCAN: begin
                case (sub_reg)
                    4'd0:    cmd.op = OP_S0;
                    4'd1:    cmd.op = OP_S1;
                    4'd2:    cmd.op = OP_S2;
                    4'd3:    cmd.op = OP_S3;
                    4'd4:    cmd.op = OP_S4;
                    4'd5:    cmd.op = OP_S5;
                    4'd6:    cmd.op = OP_S6;
                    4'd7:    cmd.op = OP_S7;
                    4'd8:    cmd.op = OP_S8;
                    default: cmd.op = OP_S9;
                endcase
            end
            ST_OUT: cmd.op = stat.out_free ? OP_S10 : OP_NOP;
            default: cmd.op = OP_NOP;
        endcase
    end

    // Checks
    a_dyn_sub: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DYN) |-> (sub_reg <= 4'd5))
        else $error("string step sub-cycle out of range");
    a_xp_sub: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_XP) |-> (sub_reg <= 4'd3 && idx_reg <= last_idx))
        else $error("excitation counter out of range");
    a_scan_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && sub_reg == 4'd9) |=> (state_reg == ST_OUT))
        else $error("sample computation did not reach output");
endmodule

[rtl/scanned_string_voice.sv]
// Scanned-synthesis string voice, top level: controller plus datapath.
// Sample request: scan steps S0 to S9, then the output stage, which waits
// while an earlier result is held.
// Dynamics request: one excitation pass for each drone or pluck (1, 16 or 64
// nodes by shape), then the string step over all nodes.
// One request at a time.
// After reset a pass over all 64 nodes clears the node memories; s_tready stays low.
// Uses ssv_pkg, ssv_ctrl, ssv_dp.
`timescale 1ns / 1ps
module scanned_string_voice (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [ssv_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ssv_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] gate
    input  logic                           s_tuser,   // [0] command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ssv_pkg::OUT_BITS-1:0]   m_tdata    // [15:0] sample_out
);
    import ssv_pkg::*;

    ssv_cmd_t  cmd;
    ssv_stat_t stat;

    ssv_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .stat(stat), .cmd(cmd)
    );

    ssv_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .cmd(cmd), .stat(stat),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );
endmodule
